[rtl/ihtd_pkg.sv]
// shared types and constants for the interrupt handler table dispatch block
// no dependencies

package ihtd_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam int IRQ_W = 10;
  localparam int HID_W = 16;
  localparam int ACK_W = 32;
  localparam int LIMIT_W = 11;
  localparam int STATUS_W = 3;

  localparam logic [IRQ_W-1:0] ID_NONE = 10'h3FF;
  localparam logic [IRQ_W-1:0] ID_SPURIOUS = 10'h3FE;

  typedef enum logic [1:0] {
    ACT_REGISTER = 2'd0,
    ACT_REMOVE   = 2'd1,
    ACT_DISPATCH = 2'd2,
    ACT_UNUSED   = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_NULL    = 3'd1,
    ST_RANGE   = 3'd2,
    ST_OTHER   = 3'd3,
    ST_FULL    = 3'd4,
    ST_MISSING = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [IRQ_W-1:0] irq;
    logic [HID_W-1:0] handler;
  } entry_t;

  // per-cell load controls
  typedef struct packed {
    logic take_next;
    logic load;
  } cell_ctl_t;

endpackage

[rtl/ihtd_cell.sv]
// one table cell: holds an entry, takes its neighbor's entry or a new one
// depends on ihtd_pkg

module ihtd_cell
  import ihtd_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  entry_t    next_entry,
  input  entry_t    new_entry,
  output entry_t    entry
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      entry <= new_entry;
    end else if (ctl.take_next) begin
      entry <= next_entry;
    end
  end

endmodule

[rtl/interrupt_handler_table_dispatch.sv]
// interrupt handler table with dispatch: row of entry cells plus sequencer
// depends on ihtd_pkg and ihtd_cell
// sequence: start moves the sequencer to S_SCAN, the scan passes every table
//   entry past the head cell, S_DONE decides and registers the result, then done rises
// a new item is taken only in S_IDLE (busy low); the table scan rotates the
//   cell ring once, one entry past the head cell per cycle
// reset: entry count, irq limit and sequencer cleared; table contents undefined
// results are shown for one cycle on done; the receiver cannot stall

module interrupt_handler_table_dispatch
  import ihtd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // command side
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          action,
  input  logic [IRQ_W-1:0]    irq,
  input  logic [HID_W-1:0]    handler_id,
  input  logic                code_present,
  input  logic [ACK_W-1:0]    ack_word,
  // result side
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic                call_valid,
  output logic [HID_W-1:0]    call_handler,
  output logic [IRQ_W-1:0]    call_irq,
  output logic                eoi_valid,
  output logic [ACK_W-1:0]    eoi_word,
  output logic                claimed,
  // configuration
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [LIMIT_W-1:0]  cfg_data
);

  state_t state, state_next;

  // item registers captured on accept
  action_t            act;
  logic [IRQ_W-1:0]   key;
  logic [HID_W-1:0]   hid;
  logic               code;
  logic [ACK_W-1:0]   ack;

  logic [LIMIT_W-1:0] irq_limit;
  logic [CNT_W-1:0]   entry_count;

  // scan bookkeeping
  logic [IDX_W-1:0]   scan_idx;
  logic               found;
  logic [IDX_W-1:0]   pos;
  logic [HID_W-1:0]   hit_handler;

  entry_t    cells [TABLE_ENTRIES];
  cell_ctl_t ctl   [TABLE_ENTRIES];
  entry_t    new_entry;

  logic accept;
  logic scan_last;
  logic key_in_range;
  logic do_append;
  logic do_remove;

  // result next values
  status_t          status_next;
  logic             call_valid_next;
  logic [HID_W-1:0] call_handler_next;
  logic [IRQ_W-1:0] call_irq_next;
  logic             eoi_valid_next;
  logic [ACK_W-1:0] eoi_word_next;
  logic             claimed_next;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign scan_last = (scan_idx == IDX_W'(TABLE_ENTRIES - 1));
  assign new_entry = '{irq: key, handler: hid};

  // a zero limit makes every number out of range, which the compare covers
  assign key_in_range = ({1'b0, key} < irq_limit);

  // ring of cells: during the scan every cell takes its upper neighbor and the
  // top cell wraps from cell 0, so cell 0 shows entry k while scan_idx is k and the
  // ring is back in place after a full turn. a remove shifts the tail down by
  // one above the hit position; an append loads the cell at the fill count.
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    if (i < TABLE_ENTRIES - 1) begin : g_mid
      assign ctl[i].take_next = (state == S_SCAN) ||
                                (do_remove && (IDX_W'(i) >= pos));
    end else begin : g_top
      assign ctl[i].take_next = (state == S_SCAN);
    end
    assign ctl[i].load = do_append && (entry_count == CNT_W'(i));

    ihtd_cell u_cell (
      .clk        (clk),
      .ctl        (ctl[i]),
      .next_entry (cells[(i + 1) % TABLE_ENTRIES]),
      .new_entry  (new_entry),
      .entry      (cells[i])
    );
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (scan_last) state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // decision made once the scan has seen every entry
  always_comb begin
    status_next       = ST_OK;
    call_valid_next   = 1'b0;
    call_handler_next = '0;
    call_irq_next     = '0;
    eoi_valid_next    = 1'b0;
    eoi_word_next     = '0;
    claimed_next      = 1'b0;
    do_append         = 1'b0;
    do_remove         = 1'b0;
    if (state == S_DONE) begin
      case (act)
        ACT_REGISTER: begin
          if (hid == '0 || !code) begin
            status_next = ST_NULL;
          end else if (!key_in_range) begin
            status_next = ST_RANGE;
          end else if (found) begin
            // same pair again is fine, another handler owns it otherwise
            status_next = (hit_handler == hid) ? ST_OK : ST_OTHER;
          end else if (entry_count >= CNT_W'(TABLE_ENTRIES)) begin
            status_next = ST_FULL;
          end else begin
            do_append = 1'b1;
          end
        end
        ACT_REMOVE: begin
          if (hid == '0) begin
            status_next = ST_NULL;
          end else if (!key_in_range) begin
            status_next = ST_RANGE;
          end else if (!found) begin
            status_next = ST_MISSING;
          end else begin
            do_remove = 1'b1;
          end
        end
        ACT_DISPATCH: begin
          // spurious and no-pending ids are dropped without an eoi
          if (key != ID_NONE && key != ID_SPURIOUS) begin
            eoi_valid_next = 1'b1;
            eoi_word_next  = ack;
            if (key_in_range) begin
              claimed_next = 1'b1;
              if (found) begin
                call_valid_next   = 1'b1;
                call_handler_next = hit_handler;
                call_irq_next     = key;
              end
            end
          end
        end
        default: begin
          // unused action: all fields stay zero
        end
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      act  <= action_t'(action);
      key  <= (action_t'(action) == ACT_DISPATCH) ? ack_word[IRQ_W-1:0] : irq;
      hid  <= handler_id;
      code <= code_present;
      ack  <= ack_word;
    end
  end

  // scan counter and first-hit tracking at the head cell
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      found    <= 1'b0;
    end else if (accept) begin
      scan_idx <= '0;
      found    <= 1'b0;
    end else if (state == S_SCAN) begin
      scan_idx <= scan_idx + IDX_W'(1);
      if (!found && cells[0].irq == key && CNT_W'(scan_idx) < entry_count) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SCAN && !found && cells[0].irq == key &&
        CNT_W'(scan_idx) < entry_count) begin
      pos         <= scan_idx;
      hit_handler <= cells[0].handler;
    end
  end

  // fill count and line limit
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      irq_limit   <= '0;
    end else begin
      if (do_append) begin
        entry_count <= entry_count + CNT_W'(1);
      end else if (do_remove) begin
        entry_count <= entry_count - CNT_W'(1);
      end
      if (cfg_valid && cfg_ready) begin
        irq_limit <= cfg_data;
      end
    end
  end

  // done strobe (high for one cycle) and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == S_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      status       <= status_next;
      call_valid   <= call_valid_next;
      call_handler <= call_handler_next;
      call_irq     <= call_irq_next;
      eoi_valid    <= eoi_valid_next;
      eoi_word     <= eoi_word_next;
      claimed      <= claimed_next;
    end
  end

  // checks
  assert property (@(posedge clk) disable iff (rst) done |-> $past(state == S_DONE))
    else $error("done strobe without a finished item");

  assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count beyond table size");

  assert property (@(posedge clk) disable iff (rst)
    (done && call_valid) |-> (claimed && eoi_valid))
    else $error("handler call without claim and eoi");

  assert property (@(posedge clk) disable iff (rst) !(do_append && do_remove))
    else $error("append and remove in the same cycle");

endmodule
